FILE: hw/rtl/igfc_pkg.sv
package igfc_pkg;

	// Default geometry of the frame store
	localparam int FRAME_BYTES_DEF = 64;
	localparam int FRAME_SLOTS_DEF = 8;

	// Width of a byte count and of a stored frame length
	localparam int LEN_W = 7;

	// Idle threshold after reset
	localparam logic [7:0] IDLE_TICKS_RST = 8'd10;

	// Input operation codes
	typedef enum logic [1:0] {
		OP_BYTE = 2'd0,
		OP_TICK = 2'd1,
		OP_POP  = 2'd2
	} op_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LEN,
		ST_STREAM
	} state_t;

endpackage

FILE: hw/rtl/idle_gap_frame_collector_unit.sv
// Channel   Dir  Handshake            Payload
// in        in   in_valid/in_ready    op, rx_byte
// out       out  out_valid/out_ready  frame_byte, frame_length, last, empty_res
// cfg       in   cfg_we               cfg_wdata (idle_ticks)
//
// A byte, a tick or a pop of an empty stack leaves the input open.
// A pop of an n-byte frame keeps the input closed until its last byte enters the
// output register: ST_LEN latches the frame length, then the single read port of
// the frame memory returns one byte per cycle into it while the output drains freely.
// Reset clears all control state at once; the memories need no clearing pass.
// A stall on the output holds the read pipeline; bytes and ticks are still taken
// while a result waits, a pop waits until the output register is free.
module idle_gap_frame_collector_unit
	import igfc_pkg::*;
#(
	parameter int FRAME_BYTES = FRAME_BYTES_DEF,
	parameter int FRAME_SLOTS = FRAME_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  op,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  frame_byte,
	output logic [5:0]  frame_length,
	output logic        last,
	output logic        empty_res
);

	// Byte index, stack position, physical slot and stack count widths
	localparam int IW = (FRAME_BYTES - 1 > 1) ? $clog2(FRAME_BYTES - 1) : 1;
	localparam int PW = (FRAME_SLOTS - 1 > 1) ? $clog2(FRAME_SLOTS - 1) : 1;
	localparam int SW = $clog2(FRAME_SLOTS);
	localparam int CW = $clog2(FRAME_SLOTS);
	localparam int AW = SW + IW;

	state_t            state_q, state_d;
	logic [7:0]        idle_ticks_q;
	logic [7:0]        idle_count_q;
	logic [LEN_W-1:0]  asm_count_q;
	logic [CW-1:0]     stack_count_q;
	logic [SW-1:0]     asm_slot_q;
	logic [SW-1:0]     map_q [FRAME_SLOTS-1];

	logic [7:0]        frame_mem [2**AW];
	logic [LEN_W-1:0]  len_mem [FRAME_SLOTS-1];
	logic [LEN_W-1:0]  len_rd_q;

	logic [SW-1:0]     slot_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  rd_idx_q;
	logic              vld_s1;
	logic              last_s1;
	logic [7:0]        rdata_s1;

	logic              out_valid_q;
	logic [7:0]        out_byte_q;
	logic [5:0]        out_len_q;
	logic              out_last_q;
	logic              out_empty_q;

	op_t               op_c;
	logic              in_acc;
	logic              byte_acc, tick_acc, pop_acc;
	logic              asm_room;
	logic [8:0]        idle_inc;
	logic              tick_end;
	logic              frame_done;
	logic              push_ok;
	logic [CW-1:0]     pos_c;
	logic [SW-1:0]     map_rd;
	logic              pop_empty;
	logic              pop_start;
	logic              take;
	logic              rd_en;

	// Decode the incoming transaction
	assign op_c     = op_t'(op);
	assign in_ready = (state_q == ST_IDLE) && ((op_c != OP_POP) || !out_valid_q || out_ready);
	assign in_acc   = in_valid && in_ready;
	assign byte_acc = in_acc && (op_c == OP_BYTE);
	assign tick_acc = in_acc && (op_c == OP_TICK);
	assign pop_acc  = in_acc && (op_c == OP_POP);

	// Idle counting and frame completion
	assign asm_room   = asm_count_q < LEN_W'(FRAME_BYTES - 1);
	assign idle_inc   = {1'b0, idle_count_q} + 9'd1;
	assign tick_end   = idle_inc >= {1'b0, idle_ticks_q};
	assign frame_done = tick_acc && tick_end && (asm_count_q != '0);
	assign push_ok    = frame_done && (stack_count_q < CW'(FRAME_SLOTS - 1));

	// Stack position: top entry for a pop, next free entry for a push
	assign pos_c  = (op_c == OP_POP) ? (stack_count_q - CW'(1)) : stack_count_q;
	assign map_rd = map_q[pos_c[PW-1:0]];

	assign pop_empty = pop_acc && (stack_count_q == '0);
	assign pop_start = pop_acc && (stack_count_q != '0);

	// Read pipeline advance
	assign take  = vld_s1 && (!out_valid_q || out_ready);
	assign rd_en = (state_q == ST_STREAM) && (rd_idx_q < len_q) && (!vld_s1 || take);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (pop_start) begin
					state_d = ST_LEN;
				end
			end
			ST_LEN: begin
				state_d = ST_STREAM;
			end
			ST_STREAM: begin
				if (take && last_s1) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the idle threshold
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_ticks_q <= IDLE_TICKS_RST;
		end else if (cfg_we) begin
			idle_ticks_q <= cfg_wdata;
		end
	end

	// Advance the idle counter and the assembly count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_count_q <= '0;
			asm_count_q  <= '0;
		end else begin
			if (byte_acc) begin
				idle_count_q <= '0;
				if (asm_room) begin
					asm_count_q <= asm_count_q + LEN_W'(1);
				end
			end else if (tick_acc) begin
				if (tick_end) begin
					idle_count_q <= idle_ticks_q;
				end else begin
					idle_count_q <= idle_inc[7:0];
				end
				if (frame_done) begin
					asm_count_q <= '0;
				end
			end
		end
	end

	// Stack of physical slots: a push hands the assembly slot to the stack and
	// takes the next free one; a pop leaves its slot in the free region
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_count_q <= '0;
			asm_slot_q    <= SW'(FRAME_SLOTS - 1);
			for (int i = 0; i < FRAME_SLOTS - 1; i++) begin
				map_q[i] <= SW'(i);
			end
		end else begin
			if (push_ok) begin
				map_q[pos_c[PW-1:0]] <= asm_slot_q;
				asm_slot_q           <= map_rd;
				stack_count_q        <= stack_count_q + CW'(1);
			end else if (pop_start) begin
				stack_count_q <= stack_count_q - CW'(1);
			end
		end
	end

	// Frame memory: assembly writes, pop reads
	always_ff @(posedge clk) begin
		if (byte_acc && asm_room) begin
			frame_mem[{asm_slot_q, asm_count_q[IW-1:0]}] <= rx_byte;
		end
		if (rd_en) begin
			rdata_s1 <= frame_mem[{slot_q, rd_idx_q[IW-1:0]}];
			last_s1  <= (rd_idx_q == (len_q - LEN_W'(1)));
		end
	end

	// Length memory, indexed by stack position
	always_ff @(posedge clk) begin
		if (push_ok) begin
			len_mem[pos_c[PW-1:0]] <= asm_count_q;
		end
		if (pop_start) begin
			len_rd_q <= len_mem[pos_c[PW-1:0]];
		end
	end

	// Latch the popped slot and its length
	always_ff @(posedge clk) begin
		if (pop_start) begin
			slot_q <= map_rd;
		end
		if (state_q == ST_LEN) begin
			len_q <= len_rd_q;
		end
	end

	// Read index and read stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
			vld_s1   <= 1'b0;
		end else begin
			if (state_q == ST_LEN) begin
				rd_idx_q <= '0;
			end else if (rd_en) begin
				rd_idx_q <= rd_idx_q + LEN_W'(1);
			end
			if (rd_en) begin
				vld_s1 <= 1'b1;
			end else if (take) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take || pop_empty) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (take) begin
			out_byte_q  <= rdata_s1;
			out_len_q   <= len_q[5:0];
			out_last_q  <= last_s1;
			out_empty_q <= 1'b0;
		end else if (pop_empty) begin
			out_byte_q  <= '0;
			out_len_q   <= '0;
			out_last_q  <= 1'b1;
			out_empty_q <= 1'b1;
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_byte   = out_byte_q;
	assign frame_length = out_len_q;
	assign last         = out_last_q;
	assign empty_res    = out_empty_q;

	// Checks
	a_busy_closed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready)
		else $error("input open while a pop is in progress");

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stack_count_q <= CW'(FRAME_SLOTS - 1))
		else $error("stack count beyond slot limit");

	a_asm_bound: assert property (@(posedge clk) disable iff (!arst_n)
		asm_count_q <= LEN_W'(FRAME_BYTES - 1))
		else $error("assembly count beyond frame limit");

	a_rd_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> (!vld_s1 || take))
		else $error("read issued over unconsumed read data");

	a_empty_form: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_empty_q) |-> (out_last_q && (out_len_q == '0)))
		else $error("empty result without last or with nonzero length");

endmodule

FILE: tb/sv/tb_idle_gap_frame_collector_unit.sv
`timescale 1ns / 100ps

module tb_idle_gap_frame_collector_unit;
	import igfc_pkg::*;

	localparam int FRAME_BYTES = FRAME_BYTES_DEF;
	localparam int FRAME_SLOTS = FRAME_SLOTS_DEF;
	localparam int MAX_LEN = FRAME_BYTES - 1;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// One popped-frame result as the block should present it
	typedef struct packed {
		logic [7:0] data;
		logic [5:0] length;
		logic       last;
		logic       empty;
	} frame_out_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] op;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] frame_byte;
	logic [5:0] frame_length;
	logic       last;
	logic       empty_res;

	// Shadow of the collector state
	logic [7:0] tb_idle_ticks;
	logic [7:0] asm_buf [FRAME_BYTES];
	int         asm_count;
	int         quiet_count;
	logic [7:0] stack_bytes [FRAME_SLOTS][FRAME_BYTES];
	int         stack_len [FRAME_SLOTS];
	int         stack_depth;

	frame_out_t popped_frame_q [$];
	int         mismatch_count = 0;
	int         items_sent = 0;
	int         cycle_count = 0;
	int         gap_pct = 0;
	int         stall_pct = 0;

	idle_gap_frame_collector_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.op           (op),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.frame_byte   (frame_byte),
		.frame_length (frame_length),
		.last         (last),
		.empty_res    (empty_res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Stall the output side at random
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	// Advance the shadow state by one accepted transaction; queue the expected results of a pop
	function automatic void collect_step(input logic [1:0] code, input logic [7:0] data);
		int nxt;
		int slot;
		int len;
		frame_out_t res;
		case (code)
			OP_BYTE: begin
				quiet_count = 0;
				if (asm_count < MAX_LEN) begin
					asm_buf[asm_count] = data;
					asm_count++;
				end
			end
			OP_TICK: begin
				nxt = quiet_count + 1;
				if (nxt >= tb_idle_ticks) begin
					nxt = tb_idle_ticks;
					if (asm_count > 0) begin
						// drop the frame when the stack is full
						if (stack_depth < FRAME_SLOTS - 1) begin
							for (int i = 0; i < asm_count; i++)
								stack_bytes[stack_depth][i] = asm_buf[i];
							stack_len[stack_depth] = asm_count;
							stack_depth++;
						end
						asm_count = 0;
					end
				end
				quiet_count = nxt & 8'hFF;
			end
			OP_POP: begin
				if (stack_depth == 0) begin
					res = '{data: 8'd0, length: 6'd0, last: 1'b1, empty: 1'b1};
					popped_frame_q.push_back(res);
				end else begin
					slot = stack_depth - 1;
					len = (stack_len[slot] > MAX_LEN) ? MAX_LEN : stack_len[slot];
					for (int i = 0; i < len; i++) begin
						res.data = stack_bytes[slot][i];
						res.length = len[5:0];
						res.last = (i + 1 == len);
						res.empty = 1'b0;
						popped_frame_q.push_back(res);
					end
					stack_len[slot] = 0;
					stack_depth = slot;
				end
			end
			default: ;
		endcase
	endfunction

	// Compare each result transaction with the oldest expected one
	always @(posedge clk) begin : check_results
		frame_out_t want;
		if (arst_n && out_valid && out_ready) begin
			if (popped_frame_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result, byte %02h", frame_byte));
			end else begin
				want = popped_frame_q.pop_front();
				if (frame_byte !== want.data)
					report_mismatch($sformatf("frame_byte %02h, want %02h",
						frame_byte, want.data));
				if (frame_length !== want.length)
					report_mismatch($sformatf("frame_length %0d, want %0d",
						frame_length, want.length));
				if (last !== want.last)
					report_mismatch($sformatf("last %b, want %b", last, want.last));
				if (empty_res !== want.empty)
					report_mismatch($sformatf("empty_res %b, want %b",
						empty_res, want.empty));
			end
		end
	end

	// Send one input transaction, idling first at random
	task automatic send_item(input logic [1:0] code, input logic [7:0] data);
		@(negedge clk);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		rx_byte <= data;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		collect_step(code, data);
		items_sent++;
	endtask

	task automatic send_ticks(input int n);
		repeat (n)
			send_item(OP_TICK, 8'($urandom));
	endtask

	// Bytes with occasional unused opcodes, then enough ticks to close the frame
	task automatic send_frame(input int n);
		repeat (n) begin
			send_item(OP_BYTE, 8'($urandom));
			if ($urandom_range(19) == 0)
				send_item(OP_UNUSED, 8'($urandom));
		end
		send_ticks((tb_idle_ticks == 0) ? 1 : tb_idle_ticks);
	endtask

	// Hold off input until every expected result has arrived
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (popped_frame_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES)
			@(posedge clk);
	endtask

	// Call only after drain_results
	task automatic write_idle_ticks(input logic [7:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		tb_idle_ticks = value;
	endtask

	task automatic test_empty_pop();
		send_item(OP_POP, 8'h00);
		send_item(OP_POP, 8'hFF);
		drain_results();
	endtask

	// Every opcode on a short frame at the reset threshold
	task automatic test_short_frame();
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, 8'hFF);
		send_item(OP_UNUSED, 8'h5A);
		send_item(OP_BYTE, 8'hA5);
		send_ticks(tb_idle_ticks + 1);
		send_item(OP_POP, 8'h00);
		send_item(OP_POP, 8'h00);
		drain_results();
	endtask

	task automatic test_zero_threshold();
		write_idle_ticks(8'd0);
		send_item(OP_BYTE, 8'h81);
		send_item(OP_TICK, 8'h00);
		send_item(OP_BYTE, 8'h7E);
		send_item(OP_BYTE, 8'h3C);
		send_item(OP_TICK, 8'hFF);
		send_item(OP_POP, 8'h00);
		send_item(OP_POP, 8'h00);
		drain_results();
	endtask

	// Idle counter above a freshly lowered threshold clamps and ends the frame
	task automatic test_threshold_lowered();
		write_idle_ticks(8'd255);
		send_item(OP_BYTE, 8'h12);
		send_item(OP_BYTE, 8'h34);
		send_ticks(20);
		drain_results();
		write_idle_ticks(8'd4);
		send_item(OP_TICK, 8'h00);
		send_item(OP_POP, 8'h00);
		drain_results();
	endtask

	// Bytes beyond the buffer depth are dropped
	task automatic test_buffer_full();
		write_idle_ticks(8'd1);
		send_frame(FRAME_BYTES + 3);
		send_item(OP_POP, 8'h00);
		drain_results();
	endtask

	// One frame more than the stack holds, then pop past empty
	task automatic test_stack_full();
		repeat (FRAME_SLOTS)
			send_frame($urandom_range(1, 3));
		repeat (FRAME_SLOTS)
			send_item(OP_POP, 8'($urandom));
		drain_results();
	endtask

	// Mostly well-formed frames and pops, with partial gaps and noise
	task automatic test_random_traffic(input int n_items);
		int stop_at;
		int pick;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 55)
				send_frame(($urandom_range(19) == 0) ?
					$urandom_range(MAX_LEN - 3, MAX_LEN + 4) : $urandom_range(1, 6));
			else if (pick < 78)
				send_item(OP_POP, 8'($urandom));
			else if (pick < 86)
				send_ticks($urandom_range(0, tb_idle_ticks));
			else if (pick < 92)
				send_item(OP_BYTE, 8'($urandom));
			else if (pick < 97)
				send_item(OP_UNUSED, 8'($urandom));
			else
				drain_results();
		end
		drain_results();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'd0;
		in_valid = 1'b0;
		op = OP_BYTE;
		rx_byte = 8'd0;
		tb_idle_ticks = IDLE_TICKS_RST;
		asm_count = 0;
		quiet_count = 0;
		stack_depth = 0;
		gap_pct = 9;
		stall_pct = 70;
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_empty_pop();
		test_short_frame();
		test_zero_threshold();
		test_threshold_lowered();
		test_buffer_full();
		test_stack_full();

		test_random_traffic(70);
		gap_pct = 70;
		stall_pct = 9;
		write_idle_ticks(8'($urandom_range(2, 8)));
		test_random_traffic(70);
		gap_pct = 0;
		stall_pct = 0;
		write_idle_ticks(8'd3);
		test_random_traffic(70);

		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
